[hw/rtl/bvp_pkg.sv]
// bvp_pkg: shared types and constants of the battery voltage to percent block
// holds the discharge curve tables, field widths and the controller/datapath structs
// no dependencies

package bvp_pkg;

    // field widths
    localparam int SAMPLE_W = 13;
    localparam int PCT_W    = 7;
    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 8;

    // built-in curve length and index width
    localparam int TABLE_LEN = 13;
    localparam int IDX_W     = 4;

    // segment arithmetic widths: width up to 500 mV, step up to 10 percent
    localparam int WID_W  = 9;
    localparam int STEP_W = 4;
    localparam int NUM_W  = WID_W + STEP_W;
    localparam int CNT_W  = 4;

    localparam logic [PCT_W-1:0] PCT_FULL = 7'd100;
    localparam logic [PCT_W-1:0] PCT_EMPTY = 7'd0;

    // breakpoints in mV, descending
    localparam logic [SAMPLE_W-1:0] CURVE_MV [TABLE_LEN] = '{
        13'd4200, 13'd4080, 13'd4000, 13'd3930, 13'd3870, 13'd3820, 13'd3790,
        13'd3770, 13'd3730, 13'd3700, 13'd3680, 13'd3500, 13'd3000
    };

    // charge at each breakpoint in percent
    localparam logic [PCT_W-1:0] CURVE_PCT [TABLE_LEN] = '{
        7'd100, 7'd90, 7'd80, 7'd70, 7'd60, 7'd50, 7'd40,
        7'd30, 7'd20, 7'd15, 7'd10, 7'd5, 7'd0
    };

    // commands from controller to datapath
    typedef struct packed {
        logic load;
        logic search;
        logic mul;
        logic div;
        logic emit;
    } t_cmd;

    // status from datapath to controller
    typedef struct packed {
        logic hit;
        logic last;
        logic top;
        logic div_last;
    } t_stat;

endpackage

[hw/rtl/bvp_ctrl.sv]
// bvp_ctrl: sequencing state machine of the battery voltage to percent block
// steps search, multiply and divide, and owns both handshakes
// depends on bvp_pkg

module bvp_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_s_tvalid,
    output logic           o_s_tready,
    output logic           o_m_tvalid,
    input  logic           i_m_tready,
    input  bvp_pkg::t_stat i_stat,
    output bvp_pkg::t_cmd  o_cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_MUL,
        ST_DIV,
        ST_FIN
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_m_tvalid;
    logic   n_m_tvalid;
    logic   w_out_free;

    assign w_out_free = !r_m_tvalid || i_m_tready;
    assign o_s_tready = (r_state == ST_IDLE);
    assign o_m_tvalid = r_m_tvalid;

    // next state and commands
    always_comb begin
        n_state    = r_state;
        n_m_tvalid = r_m_tvalid && !i_m_tready;
        o_cmd      = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_s_tvalid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_SEARCH;
                end
            end
            ST_SEARCH: begin
                o_cmd.search = 1'b1;
                if (i_stat.hit) begin
                    n_state = i_stat.top ? ST_FIN : ST_MUL;
                end else if (i_stat.last) begin
                    n_state = ST_FIN;
                end
            end
            ST_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = ST_DIV;
            end
            ST_DIV: begin
                o_cmd.div = 1'b1;
                if (i_stat.div_last) begin
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                if (w_out_free) begin
                    o_cmd.emit = 1'b1;
                    n_m_tvalid = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // state and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_m_tvalid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_m_tvalid <= n_m_tvalid;
        end
    end

    // the divider always follows the multiply, which only runs after a hit below the top breakpoint
    a_div_after_mul: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_MUL) |=> (r_state == ST_DIV))
        else $error("divide did not follow multiply");

    // a result is only emitted into a free output register
    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.emit |-> w_out_free)
        else $error("result overwrote a pending transfer");

    // no new sample is taken while one is in flight
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> !o_s_tready)
        else $error("second sample accepted while busy");

endmodule

[hw/rtl/bvp_dp.sv]
// bvp_dp: datapath of the battery voltage to percent block
// serial breakpoint search, segment multiply, restoring divider and result register
// depends on bvp_pkg

module bvp_dp #(
    parameter int N_USE = 13,
    parameter int K_W   = 4
) (
    input  logic                          i_clk,
    input  logic [bvp_pkg::SAMPLE_W-1:0]  i_sample,
    input  bvp_pkg::t_cmd                 i_cmd,
    output bvp_pkg::t_stat                o_stat,
    output logic [bvp_pkg::PCT_W-1:0]     o_pct,
    output logic                          o_below
);

    localparam int SW = bvp_pkg::SAMPLE_W;
    localparam int PW = bvp_pkg::PCT_W;
    localparam int WW = bvp_pkg::WID_W;
    localparam int NW = bvp_pkg::NUM_W;
    localparam int CW = bvp_pkg::CNT_W;
    localparam int IW = bvp_pkg::IDX_W;

    logic [SW-1:0] r_sample;
    logic [K_W-1:0] r_k;
    logic          r_below;
    logic [WW-1:0] r_width;
    logic [PW-1:0] r_pct_lo;
    logic [NW-1:0] r_num;
    logic [WW-1:0] r_rem;
    logic [CW-1:0] r_cnt;
    logic [PW-1:0] r_pct;
    logic          r_out_below;

    logic [IW-1:0]   w_idx;
    logic [IW-1:0]   w_idx_up;
    logic [SW-1:0]   w_mv;
    logic [SW-1:0]   w_mv_up;
    logic [SW-1:0]   w_excess;
    logic [SW-1:0]   w_span;
    logic [PW-1:0]   w_pct_diff;
    logic [NW-1:0]   w_product;
    logic [WW:0]     w_trial;
    logic            w_q;
    logic [PW-1:0]   w_result;

    // table lookups at the current and the next higher breakpoint
    assign w_idx      = IW'(r_k);
    assign w_idx_up   = w_idx - 1'b1;
    assign w_mv       = bvp_pkg::CURVE_MV[w_idx];
    assign w_mv_up    = bvp_pkg::CURVE_MV[w_idx_up];
    assign w_excess   = r_sample - w_mv;
    assign w_span     = w_mv_up - w_mv;
    assign w_pct_diff = bvp_pkg::CURVE_PCT[w_idx_up] - bvp_pkg::CURVE_PCT[w_idx];
    assign w_product  = NW'(w_excess[WW-1:0]) * NW'(w_pct_diff[bvp_pkg::STEP_W-1:0]);

    // one restoring divide step
    assign w_trial = {r_rem, r_num[NW-1]};
    assign w_q     = (w_trial >= {1'b0, r_width});

    assign o_stat.hit      = (r_sample >= w_mv);
    assign o_stat.last     = (r_k == K_W'(N_USE - 1));
    assign o_stat.top      = (r_k == '0);
    assign o_stat.div_last = (r_cnt == CW'(NW - 1));

    // final value for the finished sample
    always_comb begin
        if (r_below) begin
            w_result = bvp_pkg::PCT_EMPTY;
        end else if (r_k == '0) begin
            w_result = bvp_pkg::PCT_FULL;
        end else begin
            w_result = r_pct_lo + r_num[PW-1:0];
        end
    end

    // search index and below-range flag
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_sample <= i_sample;
            r_k      <= '0;
            r_below  <= 1'b0;
        end else if (i_cmd.search && !o_stat.hit) begin
            if (o_stat.last) begin
                r_below <= 1'b1;
            end else begin
                r_k <= r_k + 1'b1;
            end
        end
    end

    // segment setup and divider
    always_ff @(posedge i_clk) begin
        if (i_cmd.mul) begin
            r_width  <= w_span[WW-1:0];
            r_pct_lo <= bvp_pkg::CURVE_PCT[w_idx];
            r_num    <= w_product;
            r_rem    <= '0;
            r_cnt    <= '0;
        end else if (i_cmd.div) begin
            r_rem <= w_q ? WW'(w_trial - {1'b0, r_width}) : w_trial[WW-1:0];
            r_num <= {r_num[NW-2:0], w_q};
            r_cnt <= r_cnt + 1'b1;
        end
    end

    // output payload register
    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_pct       <= w_result;
            r_out_below <= r_below;
        end
    end

    assign o_pct   = r_pct;
    assign o_below = r_out_below;

endmodule

[hw/rtl/battery_voltage_to_percent.sv]
// battery_voltage_to_percent: battery sample in mV to remaining charge in percent
// sequence: accept, then a serial search over the N breakpoints in use, then a multiply and
//   a bit-serial restoring divide only when interpolating, then the result; a sample at or above
//   the top breakpoint goes straight to the result, as does one below the lowest after the search
// throughput: one sample at a time, next accept the cycle after the result is registered
// a finished result waits in the output register while the next sample is taken
// reset (synchronous, active low) clears the state machine and output valid
// depends on bvp_pkg, bvp_ctrl, bvp_dp

module battery_voltage_to_percent #(
    parameter int CURVE_POINTS = 13
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [15:0] i_s_tdata,   // [12:0] sample_mv, [15:13] zero
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [7:0]  o_m_tdata,   // [6:0] charge_percent, [7] zero
    output logic        o_m_tuser    // [0] below_empty
);

    localparam int N_CLAMP = (CURVE_POINTS > bvp_pkg::TABLE_LEN) ?
                             bvp_pkg::TABLE_LEN : CURVE_POINTS;
    localparam int N_USE   = (N_CLAMP < 2) ? 2 : N_CLAMP;
    localparam int K_W     = $clog2(N_USE);

    bvp_pkg::t_cmd  w_cmd;
    bvp_pkg::t_stat w_stat;
    logic [bvp_pkg::PCT_W-1:0] w_pct;
    logic                      w_below;

    // sequencer
    bvp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    // search and interpolation datapath
    bvp_dp #(
        .N_USE (N_USE),
        .K_W   (K_W)
    ) u_dp (
        .i_clk    (i_clk),
        .i_sample (i_s_tdata[bvp_pkg::SAMPLE_W-1:0]),
        .i_cmd    (w_cmd),
        .o_stat   (w_stat),
        .o_pct    (w_pct),
        .o_below  (w_below)
    );

    assign o_m_tdata = {{(bvp_pkg::OUT_TDATA_W - bvp_pkg::PCT_W){1'b0}}, w_pct};
    assign o_m_tuser = w_below;

    // below-range results always read as empty
    a_below_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser) |-> (o_m_tdata[6:0] == 7'd0))
        else $error("below-range result not empty");

    // charge never exceeds full
    a_pct_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata[6:0] <= 7'd100))
        else $error("charge above 100 percent");

    // a stalled result stays valid and unchanged
    a_hold_while_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=> (o_m_tvalid && $stable(o_m_tdata) &&
        $stable(o_m_tuser)))
        else $error("stalled result changed");

endmodule
